[hdl/fnvht_pkg.sv]
// Shared types, constants and hash step for the FNV-1a linear-probe hash table.
`timescale 1ns / 1ps

package fnvht_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;

  localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] key;
    logic [31:0] val;
  } entry_t;

  // One FNV-1a round: fold in a byte, then multiply by the prime (low 32 bits).
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

endpackage

[hdl/fnvht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fnvht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/fnv_hash_table_linear_probe.sv]
// Key/value hash table: FNV-1a hash, open addressing with linear probing.
// Insert/lookup: an accept state, four FNV-1a byte rounds on one shared multiplier,
// one RAM read per probed slot (single RAM read port), then a result state.
// Clear request: sweeps all CAPACITY rows, one RAM row cleared per cycle.
// After reset the block sweeps all CAPACITY rows (in_ready low).
// One item at a time; entry count and control state reset, table contents via sweep.
`timescale 1ns / 1ps

module fnv_hash_table_linear_probe
  import fnvht_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [31:0]        in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic signed [31:0] out_value_out,
  output logic               out_is_new,
  output logic               out_status
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned LIMIT = (3 * CAPACITY) / 4;
  localparam int unsigned EW    = $bits(entry_t);

  state_t         state_r, state_nxt;
  logic [1:0]     req_r, req_nxt;
  logic [31:0]    key_r, key_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [31:0]    hash_r, hash_nxt;
  logic [1:0]     hcnt_r, hcnt_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  pc_r, pc_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           found_r, found_nxt;
  logic [31:0]    vout_r, vout_nxt;
  logic           new_r, new_nxt;
  logic           stat_r, stat_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [EW-1:0]  ram_rdata;
  entry_t         rd_ent;

  logic [31:0]    hash_new;
  logic           probe_stop;
  logic           probe_end;
  logic           sweep_end;
  logic           load_full;

  fnvht_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent     = entry_t'(ram_rdata);
  assign hash_new   = fnv_step(hash_r, key_r[{hcnt_r, 3'b000} +: 8]);
  assign probe_stop = !rd_ent.vld || (rd_ent.key == key_r);
  assign probe_end  = (pc_r == {AW{1'b1}});
  assign sweep_end  = (idx_r == {AW{1'b1}});
  assign load_full  = (cnt_r >= CW'(LIMIT));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sweep_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_req_type == REQ_INSERT || in_req_type == REQ_LOOKUP) begin
            state_nxt = ST_HASH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_HASH: begin
        if (hcnt_r == 2'd3) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (probe_stop || probe_end) state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        if (sweep_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    req_nxt   = req_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    hash_nxt  = hash_r;
    hcnt_nxt  = hcnt_r;
    idx_nxt   = idx_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    vout_nxt  = vout_r;
    new_nxt   = new_r;
    stat_nxt  = stat_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    ram_raddr = idx_r;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        // drop one row's valid mark per cycle
        ram_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          key_nxt   = in_key;
          val_nxt   = in_value;
          hash_nxt  = FNV_OFFSET;
          hcnt_nxt  = 2'd0;
          pc_nxt    = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          vout_nxt  = '0;
          new_nxt   = 1'b0;
          stat_nxt  = 1'b0;
          if (in_req_type == REQ_CLEAR) cnt_nxt = '0;
        end
      end
      ST_HASH: begin
        hash_nxt = hash_new;
        hcnt_nxt = hcnt_r + 2'd1;
        if (hcnt_r == 2'd3) begin
          // issue the home slot read
          idx_nxt   = hash_new[AW-1:0];
          ram_raddr = hash_new[AW-1:0];
        end
      end
      ST_PROBE: begin
        if (probe_stop) begin
          ram_wdata = {1'b1, key_r, val_r};
          if (req_r == REQ_INSERT) begin
            if (rd_ent.vld) begin
              ram_we = 1'b1;
            end else if (load_full) begin
              stat_nxt = 1'b1;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              new_nxt = 1'b1;
            end
          end else if (rd_ent.vld) begin
            found_nxt = 1'b1;
            vout_nxt  = rd_ent.val;
          end
        end else if (probe_end) begin
          if (req_r == REQ_INSERT) stat_nxt = 1'b1;
        end else begin
          // advance to the next slot, wrapping at the top
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
          pc_nxt    = pc_r + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      idx_r   <= '0;
      cnt_r   <= '0;
      hcnt_r  <= 2'd0;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      hcnt_r  <= hcnt_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    hash_r  <= hash_nxt;
    found_r <= found_nxt;
    vout_r  <= vout_nxt;
    new_r   <= new_nxt;
    stat_r  <= stat_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = (state_r == ST_DONE);
  assign out_found     = found_r;
  assign out_value_out = vout_r;
  assign out_is_new    = new_r;
  assign out_status    = stat_r;

endmodule
